/* hdl/est_pkg.sv */
// ----------------------------------------------------------------------------
// est_pkg: shared types for the expiry sorted table
// Request kinds, status codes, the entry record held by each cell and the
// command bus that the control logic broadcasts along the cell chain.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned CoordW = 8;
  localparam int unsigned LifeW  = 16;
  localparam int unsigned CountW = 5;

  // Request kinds as they arrive on kind_i.
  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 3'd0,
    KIND_LOOKUP = 3'd1,
    KIND_TICK   = 3'd2,
    KIND_PURGE  = 3'd3,
    KIND_DUMP   = 3'd4
  } kind_e;

  // Status codes reported with each result.
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2,
    STATUS_ZERO = 2'd3
  } status_e;

  // Command that every cell executes in the same cycle.
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_TICK   = 3'd2,
    CELL_SHIFT  = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_cmd_e;

  // One table entry.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [LifeW-1:0]  remaining;
    logic [LifeW-1:0]  initial_life;
  } entry_t;

  // Broadcast bus from the control logic to all cells.
  typedef struct packed {
    cell_cmd_e cmd;
    entry_t    ins;
  } cell_bus_t;

endpackage

/* hdl/est_cell.sv */
// ----------------------------------------------------------------------------
// est_cell: one slot of the sorted table
// Holds one entry, compares it against the broadcast request and takes its
// next value from itself, its left or right neighbor, the head or the new
// entry, as the broadcast command says.
// ----------------------------------------------------------------------------
module est_cell
  import est_pkg::*;
(
  input  logic      clk_i,
  input  cell_bus_t bus_i,
  input  logic      active_i,
  input  logic      tail_i,
  input  logic      prev_lt_i,
  input  entry_t    left_i,
  input  entry_t    right_i,
  input  entry_t    head_i,
  output entry_t    entry_o,
  output logic      lt_o,
  output logic      match_o
);

  entry_t entry_q, entry_d;

  // Compare against the request: sort position and coordinate match.
  assign lt_o    = active_i && (entry_q.remaining < bus_i.ins.remaining);
  assign match_o = active_i && (entry_q.x == bus_i.ins.x) && (entry_q.y == bus_i.ins.y);
  assign entry_o = entry_q;

  // Next value of the slot.
  always_comb begin
    entry_d = entry_q;
    case (bus_i.cmd)
      CELL_INSERT: begin
        // Entries below the new lifetime stay; the first other slot takes
        // the new entry and the rest move one place to the right.
        if (!lt_o) begin
          entry_d = prev_lt_i ? bus_i.ins : left_i;
        end
      end
      CELL_TICK: begin
        if (entry_q.remaining != '0) begin
          entry_d.remaining = entry_q.remaining - LifeW'(1);
        end
      end
      CELL_SHIFT: begin
        entry_d = right_i;
      end
      CELL_ROTATE: begin
        // The last occupied slot wraps the head around.
        entry_d = tail_i ? head_i : right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* hdl/expiry_sorted_table.sv */
// ----------------------------------------------------------------------------
// expiry_sorted_table: table of coordinates sorted by remaining lifetime
// A chain of DEPTH cells holds the entries in ascending order of remaining
// lifetime; a small controller broadcasts one command along the chain.
// ----------------------------------------------------------------------------
// Usage: a request (kind_i, pos_x_i, pos_y_i, life_i) is taken at a clock
// edge where start is high and busy is low. Each result appears for one
// cycle with strobe_o high; the receiver cannot stall, so it must take it.
// Insert, lookup, tick and unused kinds produce one result in the cycle
// after the request and leave busy low, so a new request may follow at
// once. All cells compare and shift in parallel. A purge walks the chain
// one removed entry per cycle with busy high, until the head holds no
// expired entry, and then gives one result. A dump rotates the chain one
// slot per cycle with busy high, once per entry, and gives one result per
// entry: the request first enters the dump state, each rotation step
// registers one result, and the results follow back to back. A dump of an
// empty table gives its single result in the cycle after the request and
// leaves busy low. The rotation returns the table to its original order.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module expiry_sorted_table
  import est_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [KindW-1:0]    kind_i,
  input  logic [CoordW-1:0]   pos_x_i,
  input  logic [CoordW-1:0]   pos_y_i,
  input  logic [LifeW-1:0]    life_i,
  output logic                strobe_o,
  output logic [1:0]          status_o,
  output logic                found_o,
  output logic [CountW-1:0]   removed_count_o,
  output logic [CountW-1:0]   occupancy_o,
  output logic [CoordW-1:0]   entry_x_o,
  output logic [CoordW-1:0]   entry_y_o,
  output logic [LifeW-1:0]    entry_initial_o,
  output logic [LifeW-1:0]    entry_remaining_o,
  output logic                last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PURGE = 3'b010,
    ST_DUMP  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] aux_q, aux_d;
  cell_bus_t       bus;
  logic            accept;

  entry_t     cell_ent [DEPTH];
  entry_t     left_ent [DEPTH];
  entry_t     right_ent [DEPTH];
  logic [DEPTH-1:0] cell_lt;
  logic [DEPTH-1:0] prev_lt;
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] cell_active;
  logic [DEPTH-1:0] cell_tail;

  logic            any_match;
  logic            head_zero;
  logic            dump_last;

  logic            strobe_q, strobe_d;
  status_e         status_q, status_d;
  logic            found_q, found_d;
  logic [CntW-1:0] removed_q, removed_d;
  logic [CntW-1:0] occ_q;
  entry_t          ent_q, ent_d;
  logic            last_q, last_d;

  // Cell chain with neighbor links.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_active[i] = (CntW'(i) < count_q);
    assign cell_tail[i]   = (count_q == CntW'(i + 1));

    if (i == 0) begin : g_first
      assign left_ent[i] = cell_ent[i];
      assign prev_lt[i]  = 1'b1;
    end else begin : g_inner
      assign left_ent[i] = cell_ent[i-1];
      assign prev_lt[i]  = cell_lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_ent[i] = cell_ent[0];
    end else begin : g_mid
      assign right_ent[i] = cell_ent[i+1];
    end

    est_cell u_cell (
      .clk_i     (clk_i),
      .bus_i     (bus),
      .active_i  (cell_active[i]),
      .tail_i    (cell_tail[i]),
      .prev_lt_i (prev_lt[i]),
      .left_i    (left_ent[i]),
      .right_i   (right_ent[i]),
      .head_i    (cell_ent[0]),
      .entry_o   (cell_ent[i]),
      .lt_o      (cell_lt[i]),
      .match_o   (cell_match[i])
    );
  end

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign any_match = |cell_match;
  assign head_zero = (count_q != '0) && (cell_ent[0].remaining == '0);
  assign dump_last = (aux_q == count_q - CntW'(1));

  // Control: command for the chain, next state and the result.
  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    aux_d            = aux_q;
    bus.cmd          = CELL_HOLD;
    bus.ins.x        = pos_x_i;
    bus.ins.y        = pos_y_i;
    bus.ins.remaining    = life_i;
    bus.ins.initial_life = life_i;
    strobe_d         = 1'b0;
    status_d         = STATUS_OK;
    found_d          = 1'b0;
    removed_d        = '0;
    ent_d            = '0;
    last_d           = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_INSERT: begin
              strobe_d = 1'b1;
              if (life_i == '0) begin
                status_d = STATUS_ZERO;
              end else if (any_match) begin
                status_d = STATUS_DUP;
              end else if (count_q == CntW'(DEPTH)) begin
                status_d = STATUS_FULL;
              end else begin
                bus.cmd = CELL_INSERT;
                count_d = count_q + CntW'(1);
              end
            end
            KIND_LOOKUP: begin
              strobe_d = 1'b1;
              found_d  = any_match;
            end
            KIND_TICK: begin
              strobe_d = 1'b1;
              bus.cmd  = CELL_TICK;
            end
            KIND_PURGE: begin
              aux_d   = '0;
              state_d = ST_PURGE;
            end
            KIND_DUMP: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
              end else begin
                aux_d   = '0;
                state_d = ST_DUMP;
              end
            end
            default: begin
              strobe_d = 1'b1;
            end
          endcase
        end
      end
      ST_PURGE: begin
        // Expired entries sit at the head; drop one per cycle.
        if (head_zero) begin
          bus.cmd = CELL_SHIFT;
          count_d = count_q - CntW'(1);
          aux_d   = aux_q + CntW'(1);
        end else begin
          strobe_d  = 1'b1;
          removed_d = aux_q;
          state_d   = ST_IDLE;
        end
      end
      ST_DUMP: begin
        // Emit the head and rotate the occupied part of the chain.
        bus.cmd  = CELL_ROTATE;
        strobe_d = 1'b1;
        ent_d    = cell_ent[0];
        last_d   = dump_last;
        aux_d    = aux_q + CntW'(1);
        if (dump_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      aux_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      aux_q    <= aux_d;
      strobe_q <= strobe_d;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (strobe_d) begin
      status_q  <= status_d;
      found_q   <= found_d;
      removed_q <= removed_d;
      occ_q     <= count_d;
      ent_q     <= ent_d;
      last_q    <= last_d;
    end
  end

  assign strobe_o          = strobe_q;
  assign status_o          = status_q;
  assign found_o           = found_q;
  assign removed_count_o   = CountW'(removed_q);
  assign occupancy_o       = CountW'(occ_q);
  assign entry_x_o         = ent_q.x;
  assign entry_y_o         = ent_q.y;
  assign entry_initial_o   = ent_q.initial_life;
  assign entry_remaining_o = ent_q.remaining;
  assign last_o            = last_q;

  // The fill count never passes the chain length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above table depth");

  // A purge that still finds an expired head gives no result yet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PURGE && head_zero) |=> !strobe_o)
    else $error("purge result before all expired entries were removed");

  // A zero-lifetime insert is rejected in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_INSERT && life_i == '0) |=>
      (strobe_o && status_o == STATUS_ZERO && last_o))
    else $error("zero lifetime insert not rejected");

  // Every dump step before the final one yields a result not marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && !dump_last) |=> (strobe_o && !last_o && busy))
    else $error("dump ended early");

  // A tick leaves the fill count unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_TICK) |=> (count_q == $past(count_q)))
    else $error("tick changed the fill count");

endmodule

/* bench/tb_expiry_sorted_table.sv */
// ----------------------------------------------------------------------------
// tb_expiry_sorted_table: self-checking bench for the expiry sorted table
// A driver sends requests from a pending queue in random bursts, and a
// monitor keeps a shadow of the sorted table to predict every result. Each
// strobed result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_expiry_sorted_table;
  import est_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned POOL_SIZE  = 32;
  localparam int unsigned QUIET_MAX  = 1000;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned PRINT_MAX  = 40;

  // Kind codes that the block does not use.
  localparam logic [KindW-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KindW-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [LifeW-1:0]  life;
  } table_request_t;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [CountW-1:0] removed;
    logic [CountW-1:0] occupancy;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [LifeW-1:0]  initial_life;
    logic [LifeW-1:0]  remaining;
    logic              last;
  } table_result_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic [KindW-1:0]    kind_i  = '0;
  logic [CoordW-1:0]   pos_x_i = '0;
  logic [CoordW-1:0]   pos_y_i = '0;
  logic [LifeW-1:0]    life_i  = '0;
  logic                busy;
  logic                strobe_o;
  logic [1:0]          status_o;
  logic                found_o;
  logic [CountW-1:0]   removed_count_o;
  logic [CountW-1:0]   occupancy_o;
  logic [CoordW-1:0]   entry_x_o;
  logic [CoordW-1:0]   entry_y_o;
  logic [LifeW-1:0]    entry_initial_o;
  logic [LifeW-1:0]    entry_remaining_o;
  logic                last_o;

  table_request_t pending_requests[$];
  table_result_t  expected_results[$];
  table_request_t next_request;
  table_result_t  oldest_expected;

  // Shadow of the sorted table.
  logic [CoordW-1:0] held_x        [DEPTH];
  logic [CoordW-1:0] held_y        [DEPTH];
  logic [LifeW-1:0]  held_remaining[DEPTH];
  logic [LifeW-1:0]  held_initial  [DEPTH];
  int                held_count = 0;

  int mismatch_count = 0;
  int burst_left     = 8;
  int gap_left       = 0;
  int quiet_cycles   = 0;

  expiry_sorted_table #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .life_i           (life_i),
    .strobe_o         (strobe_o),
    .status_o         (status_o),
    .found_o          (found_o),
    .removed_count_o  (removed_count_o),
    .occupancy_o      (occupancy_o),
    .entry_x_o        (entry_x_o),
    .entry_y_o        (entry_y_o),
    .entry_initial_o  (entry_initial_o),
    .entry_remaining_o(entry_remaining_o),
    .last_o           (last_o)
  );

  always begin
    #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [LifeW-1:0] got,
                             input logic [LifeW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic queue_request(input logic [KindW-1:0] kind,
                               input logic [CoordW-1:0] x,
                               input logic [CoordW-1:0] y,
                               input logic [LifeW-1:0] life);
    table_request_t req;
    req.kind = kind;
    req.x    = x;
    req.y    = y;
    req.life = life;
    pending_requests.push_back(req);
  endtask

  // Apply one accepted request to the shadow table and queue its results.
  task automatic predict_request(input logic [KindW-1:0] kind,
                                 input logic [CoordW-1:0] px,
                                 input logic [CoordW-1:0] py,
                                 input logic [LifeW-1:0] life);
    table_result_t res;
    int            at;
    int            n;
    int            i;
    bit            present;
    bit            dumped;
    res      = '0;
    res.last = 1'b1;
    present  = 1'b0;
    dumped   = 1'b0;
    for (i = 0; i < held_count; i++) begin
      if (held_x[i] == px && held_y[i] == py) present = 1'b1;
    end
    case (kind)
      KIND_INSERT: begin
        // Zero lifetime wins over a duplicate, which wins over a full table.
        if (life == '0) begin
          res.status = STATUS_ZERO;
        end else if (present) begin
          res.status = STATUS_DUP;
        end else if (held_count >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          at = 0;
          while (at < held_count && held_remaining[at] < life) at++;
          for (i = held_count; i > at; i--) begin
            held_x[i]         = held_x[i-1];
            held_y[i]         = held_y[i-1];
            held_remaining[i] = held_remaining[i-1];
            held_initial[i]   = held_initial[i-1];
          end
          held_x[at]         = px;
          held_y[at]         = py;
          held_remaining[at] = life;
          held_initial[at]   = life;
          held_count++;
        end
      end
      KIND_LOOKUP: begin
        res.found = present;
      end
      KIND_TICK: begin
        // Remaining lifetimes saturate at zero.
        for (i = 0; i < held_count; i++) begin
          if (held_remaining[i] != '0) held_remaining[i] = held_remaining[i] - LifeW'(1);
        end
      end
      KIND_PURGE: begin
        n = 0;
        while (n < held_count && held_remaining[n] == '0) n++;
        for (i = n; i < held_count; i++) begin
          held_x[i-n]         = held_x[i];
          held_y[i-n]         = held_y[i];
          held_remaining[i-n] = held_remaining[i];
          held_initial[i-n]   = held_initial[i];
        end
        held_count  = held_count - n;
        res.removed = CountW'(n);
      end
      KIND_DUMP: begin
        // An empty table still gives one result, marked last.
        for (i = 0; i < held_count; i++) begin
          res.occupancy    = CountW'(held_count);
          res.x            = held_x[i];
          res.y            = held_y[i];
          res.initial_life = held_initial[i];
          res.remaining    = held_remaining[i];
          res.last         = (i + 1 == held_count);
          expected_results.push_back(res);
          dumped = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!dumped) begin
      res.occupancy = CountW'(held_count);
      expected_results.push_back(res);
    end
  endtask

  // Driver: present requests in bursts, hold each until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        start <= 1'b0;
      end else begin
        next_request = pending_requests.pop_front();
        kind_i  <= next_request.kind;
        pos_x_i <= next_request.x;
        pos_y_i <= next_request.y;
        life_i  <= next_request.life;
        start   <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: check strobed results, then predict for the accepted request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result strobed with no request outstanding");
        end else begin
          oldest_expected = expected_results.pop_front();
          check_field("status", LifeW'(status_o), LifeW'(oldest_expected.status));
          check_field("found", LifeW'(found_o), LifeW'(oldest_expected.found));
          check_field("removed_count", LifeW'(removed_count_o),
                      LifeW'(oldest_expected.removed));
          check_field("occupancy", LifeW'(occupancy_o), LifeW'(oldest_expected.occupancy));
          check_field("entry_x", LifeW'(entry_x_o), LifeW'(oldest_expected.x));
          check_field("entry_y", LifeW'(entry_y_o), LifeW'(oldest_expected.y));
          check_field("entry_initial", entry_initial_o, oldest_expected.initial_life);
          check_field("entry_remaining", entry_remaining_o, oldest_expected.remaining);
          check_field("last", LifeW'(last_o), LifeW'(oldest_expected.last));
        end
      end
      if (start && !busy) begin
        predict_request(kind_i, pos_x_i, pos_y_i, life_i);
      end
    end
  end

  // Watchdog on cycles with neither a request nor a result taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [CoordW-1:0] pool_x[POOL_SIZE];
    logic [CoordW-1:0] pool_y[POOL_SIZE];
    logic [LifeW-1:0]  life_v;
    int                idx;
    int                n;
    int                p;

    // Directed part: empty table cases, spare kinds, a fill to full, then requests on the full table.
    queue_request(KIND_DUMP, 8'd0, 8'd0, 16'd0);
    queue_request(KIND_PURGE, 8'd0, 8'd0, 16'd0);
    queue_request(KIND_LOOKUP, 8'd255, 8'd255, 16'd0);
    queue_request(KIND_INSERT, 8'd255, 8'd0, 16'd0);
    queue_request(KIND_SPARE_LO, 8'd17, 8'd34, 16'd5);
    queue_request(KIND_SPARE_HI, 8'd255, 8'd255, 16'hFFFF);
    for (idx = 0; idx < DEPTH; idx++) begin
      // Two equal lifetimes test the insert-before-equal rule.
      if (idx < 2) life_v = 16'd1;
      else if (idx == 2) life_v = 16'hFFFF;
      else life_v = LifeW'($urandom_range(2, 9));
      queue_request(KIND_INSERT, CoordW'(idx), CoordW'(255 - idx), life_v);
    end
    queue_request(KIND_INSERT, 8'd0, 8'd255, 16'd0);
    queue_request(KIND_INSERT, 8'd0, 8'd255, 16'd3);
    queue_request(KIND_INSERT, 8'd200, 8'd200, 16'd2);
    queue_request(KIND_LOOKUP, 8'd0, 8'd255, 16'd0);
    queue_request(KIND_TICK, 8'd0, 8'd0, 16'd0);
    queue_request(KIND_TICK, 8'd0, 8'd0, 16'd0);
    queue_request(KIND_DUMP, 8'd0, 8'd0, 16'd0);
    queue_request(KIND_PURGE, 8'd0, 8'd0, 16'd0);

    // A small coordinate pool makes duplicates, hits and full tables common.
    pool_x[0] = 8'd0;
    pool_y[0] = 8'd0;
    pool_x[1] = 8'd255;
    pool_y[1] = 8'd255;
    for (idx = 2; idx < POOL_SIZE; idx++) begin
      pool_x[idx] = CoordW'($urandom);
      pool_y[idx] = CoordW'($urandom);
    end

    // Random part: mostly fill, age and purge sequences, with some noise.
    while (pending_requests.size() < 115) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(3, 20);
          for (idx = 0; idx < n; idx++) begin
            case ($urandom_range(0, 9))
              0:       life_v = 16'd0;
              1, 2:    life_v = LifeW'($urandom);
              default: life_v = LifeW'($urandom_range(1, 6));
            endcase
            p = $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 9) < 7) begin
              queue_request(KIND_INSERT, pool_x[p], pool_y[p], life_v);
            end else begin
              queue_request(KIND_INSERT, CoordW'($urandom), CoordW'($urandom), life_v);
            end
          end
        end
        4, 5: begin
          n = $urandom_range(1, 5);
          for (idx = 0; idx < n; idx++) begin
            queue_request(KIND_TICK, CoordW'($urandom), CoordW'($urandom),
                          LifeW'($urandom));
          end
          queue_request(KIND_PURGE, CoordW'($urandom), CoordW'($urandom), LifeW'($urandom));
          if ($urandom_range(0, 1) == 1) queue_request(KIND_DUMP, 8'd0, 8'd0, 16'd0);
        end
        6: begin
          n = $urandom_range(1, 4);
          for (idx = 0; idx < n; idx++) begin
            p = $urandom_range(0, POOL_SIZE - 1);
            queue_request(KIND_LOOKUP, pool_x[p], pool_y[p], LifeW'($urandom));
          end
        end
        7: queue_request(KIND_DUMP, CoordW'($urandom), CoordW'($urandom), LifeW'($urandom));
        8: begin
          n = $urandom_range(1, 3);
          for (idx = 0; idx < n; idx++) begin
            queue_request(KindW'($urandom_range(0, 7)), CoordW'($urandom),
                          CoordW'($urandom), LifeW'($urandom));
          end
        end
        default: queue_request(KIND_PURGE, 8'd0, 8'd0, 16'd0);
      endcase
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample on the falling edge so the driver's updates have settled.
    while (pending_requests.size() != 0 || start || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
